>>> rtl/gter_pkg.sv
// Shared types and constants for the GTP-U echo responder.
// No dependencies.
`default_nettype none
package gter_pkg;
  localparam int BUF_WORDS = 24;
  localparam int ADDR_W    = $clog2(BUF_WORDS);
  localparam int CFG_IDX_W = 8;
  localparam int SUM_W     = 22;

  localparam logic [CFG_IDX_W-1:0] REG_IPV4_TTL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IPV6_HOP  = 8'd1;

  localparam logic [15:0] UDP_LEN   = 16'd22;
  localparam logic [15:0] GTP_LEN   = 16'd6;
  localparam logic [7:0]  GTP_ECHO_RESP = 8'd2;
  localparam logic [7:0]  IE_RECOVERY   = 8'd14;
  // pseudo header length + UDP length + GTP length + recovery IE type byte
  localparam logic [SUM_W-1:0] UDP_CONST = 22'h000e32;

  typedef enum logic [2:0] {
    S_IN, S_BAD, S_SCAN, S_DRAIN, S_FOLD, S_EMIT
  } state_t;
endpackage
`default_nettype wire

>>> rtl/gtpu_echo_responder_unit.sv
// GTP-U echo responder top level: header buffer, checksum scan, response emit.
// Depends on gter_pkg and gter_ram.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | tdata {frag_id, pkt_word}, tuser mode, tlast
// m_axis  | out | m_axis_tvalid/tready   | tdata {valid_bytes, resp_word}, tuser malformed, tlast
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// Request words are taken one per cycle and written to the header RAM.
// After the last word the block stops taking input, reads need = H+5 header
// words (H = IP header words) to build checksums, then emits H+6 words, both
// paced by the one RAM read port; each emit read waits for the last to return.
// Synchronous reset clears control and loads TTL and hop limit with 64.
// A stalled output holds its item; the input stalls until the response is issued.
`default_nettype none
module gtpu_echo_responder_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // [31:0] pkt_word, [47:32] frag_id
  input  logic                          s_axis_tuser,  // mode
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,  // [31:0] resp_word, [34:32] valid_bytes
  output logic                          m_axis_tuser,  // malformed
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gter_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);
  import gter_pkg::*;

  state_t state, state_next;

  logic [7:0]  ttl, hop;
  logic [4:0]  cnt;
  logic        mode;
  logic [15:0] fid;
  logic [3:0]  ihl;
  logic [4:0]  need, hw;         // hw: IP header words
  logic [4:0]  idx;
  logic        sv, ev;           // scan / emit read outstanding
  logic [4:0]  rd_idx;
  logic [SUM_W-1:0] usum, isum, uadd, iadd;
  logic [7:0]  flags;
  logic        s_clr;
  logic [15:0] seq;
  logic [15:0] ipck, udpck;

  logic        in_acc, wr_en, issue_e, out_free, mode_eff;
  logic [3:0]  ihl_eff;
  logic [4:0]  n_words, need_eff;
  logic        bad;
  logic [ADDR_W-1:0] raddr;
  logic [31:0] d, ew;
  logic [2:0]  evb;
  logic        elast;
  logic [15:0] total;

  assign cfg_ready = 1'b1;
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign wr_en     = in_acc && (cnt < 5'(BUF_WORDS));
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign mode_eff  = (cnt == 5'd0) ? s_axis_tuser : mode;
  assign ihl_eff   = (cnt == 5'd0) ? s_axis_tdata[27:24] : ihl;
  assign n_words   = (cnt == 5'd31) ? cnt : cnt + 5'd1;
  assign need_eff  = mode_eff ? 5'd15 : {1'b0, ihl_eff} + 5'd5;
  assign bad       = (!mode_eff && (ihl_eff < 4'd5)) || (n_words < need_eff);
  assign total     = {10'd0, ihl, 2'b00} + UDP_LEN;

  function automatic logic [15:0] fold16(input logic [SUM_W-1:0] s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {11'd0, s[SUM_W-1:16]};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // address swap for the emitted IP addresses
  always_comb begin
    raddr = ADDR_W'(idx);
    if (state == S_EMIT) begin
      if (!mode) begin
        if (idx == 5'd3) raddr = ADDR_W'(4);
        else if (idx == 5'd4) raddr = ADDR_W'(3);
      end else begin
        if (idx >= 5'd2 && idx <= 5'd5) raddr = ADDR_W'(idx + 5'd4);
        else if (idx >= 5'd6 && idx <= 5'd9) raddr = ADDR_W'(idx - 5'd4);
      end
    end
  end

  gter_ram #(.WIDTH(32), .DEPTH(BUF_WORDS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cnt[ADDR_W-1:0]),
    .wdata (s_axis_tdata[31:0]),
    .raddr (raddr),
    .rdata (d)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IN:    if (in_acc && s_axis_tlast) state_next = bad ? S_BAD : S_SCAN;
      S_BAD:   if (out_free && !ev) state_next = S_IN;
      S_SCAN:  if (idx == need - 5'd1) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FOLD;
      S_FOLD:  state_next = S_EMIT;
      S_EMIT:  if (issue_e && idx == hw + 5'd5) state_next = S_IN;
      default: state_next = S_IN;
    endcase
  end

  // outputs of the controller
  always_comb begin
    s_axis_tready = (state == S_IN);
    issue_e       = (state == S_EMIT) && !ev && out_free;
  end

  // checksum contributions of the scanned word
  always_comb begin
    uadd = '0;
    iadd = '0;
    if (sv) begin
      if ((!mode && (rd_idx == 5'd3 || rd_idx == 5'd4)) ||
          (mode && rd_idx >= 5'd2 && rd_idx <= 5'd9) || rd_idx == hw) begin
        uadd = SUM_W'(d[31:16]) + SUM_W'(d[15:0]);
      end else if (mode && rd_idx == 5'd1) begin
        uadd = SUM_W'(d[15:8]);
      end else if (rd_idx == hw + 5'd2) begin
        uadd = SUM_W'({(d[31:24] & 8'hfa) | 8'h02, GTP_ECHO_RESP}) + UDP_CONST;
      end else if (rd_idx == hw + 5'd4) begin
        uadd = s_clr ? '0 : SUM_W'(d[31:16]);
      end else if (!mode && rd_idx == 5'd2) begin
        uadd = SUM_W'(d[23:16]);
      end
      if (!mode) begin
        if (rd_idx == 5'd0) begin
          iadd = SUM_W'(16'(~d[15:0])) + SUM_W'(total);
        end else if (rd_idx == 5'd1) begin
          iadd = SUM_W'(16'(~d[31:16])) + SUM_W'(fid);
        end else if (rd_idx == 5'd2) begin
          iadd = SUM_W'(16'(~d[15:0])) + SUM_W'(16'(~d[31:16])) + SUM_W'({ttl, d[23:16]});
        end
      end
    end
  end

  // response word for the emitted index
  always_comb begin
    ew    = d;
    evb   = 3'd4;
    elast = 1'b0;
    priority if (rd_idx < hw) begin
      if (!mode) begin
        if (rd_idx == 5'd0) ew = {d[31:16], total};
        else if (rd_idx == 5'd1) ew = {fid, d[15:0]};
        else if (rd_idx == 5'd2) ew = {ttl, d[23:16], ipck};
      end else if (rd_idx == 5'd1) begin
        ew = {UDP_LEN, d[15:8], hop};
      end
    end else if (rd_idx == hw) begin
      ew = {d[15:0], d[31:16]};
    end else if (rd_idx == hw + 5'd1) begin
      ew = {UDP_LEN, udpck};
    end else if (rd_idx == hw + 5'd2) begin
      ew = {flags, GTP_ECHO_RESP, GTP_LEN};
    end else if (rd_idx == hw + 5'd3) begin
      ew = '0;
    end else if (rd_idx == hw + 5'd4) begin
      ew = {seq, 16'd0};
    end else begin
      ew    = {IE_RECOVERY, 24'd0};
      evb   = 3'd2;
      elast = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IN;
      ttl           <= 8'd64;
      hop           <= 8'd64;
      cnt           <= '0;
      mode          <= 1'b0;
      fid           <= '0;
      sv            <= 1'b0;
      ev            <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IPV4_TTL) ttl <= cfg_data;
        else if (cfg_index == REG_IPV6_HOP) hop <= cfg_data;
      end
      if (in_acc) begin
        if (cnt == 5'd0) begin
          mode <= s_axis_tuser;
          fid  <= s_axis_tdata[47:32];
          ihl  <= s_axis_tdata[27:24];
        end
        if (s_axis_tlast) begin
          cnt  <= '0;
          need <= need_eff;
          hw   <= mode_eff ? 5'd10 : {1'b0, ihl_eff};
          idx  <= '0;
          usum <= '0;
          isum <= '0;
        end else if (cnt != 5'd31) begin
          cnt <= cnt + 5'd1;
        end
      end
      sv <= (state == S_SCAN);
      ev <= issue_e;
      if (state == S_SCAN || issue_e) begin
        rd_idx <= idx;
        idx    <= idx + 5'd1;
      end
      if (state == S_FOLD) begin
        idx   <= '0;
        ipck  <= ~fold16(isum);
        udpck <= (fold16(usum) == 16'hffff) ? 16'hffff : ~fold16(usum);
      end
      if (sv) begin
        usum <= usum + uadd;
        isum <= isum + iadd;
        if (rd_idx == hw + 5'd2) begin
          flags <= (d[31:24] & 8'hfa) | 8'h02;
          s_clr <= !d[25];
        end
        if (rd_idx == hw + 5'd4) seq <= s_clr ? 16'd0 : d[31:16];
      end
      if (ev) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= {5'd0, evb, ew};
        m_axis_tlast  <= elast;
        m_axis_tuser  <= 1'b0;
      end else if (state == S_BAD && out_free) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= '0;
        m_axis_tlast  <= 1'b1;
        m_axis_tuser  <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/gter_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module gter_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/gter_checker.sv
// Port-level checks for the GTP-U echo responder, bound to the top level.
// Depends on gter_pkg and gtpu_echo_responder_unit.
`default_nettype none
module gter_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import gter_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata[34:32] == 3'd0)
    else $error("malformed item not a lone last item");

  a_mid_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[34:32] == 3'd4)
    else $error("inner response item not full");

  a_tail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast && !m_axis_tuser |-> m_axis_tdata[34:32] == 3'd2)
    else $error("response tail byte count wrong");
endmodule

bind gtpu_echo_responder_unit gter_checker u_gter_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
